[hdl/ord_pkg.sv]
package ord_pkg;

	localparam int DEPTH = 16;
	localparam int WORD_BITS = 32;
	localparam int SLOT_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int CMD_BITS = 4;
	localparam int STAT_BITS = 2;

	typedef logic [CMD_BITS-1:0] cmd_t;
	localparam cmd_t CMD_PUSH_BACK  = 4'd0;
	localparam cmd_t CMD_PUSH_FRONT = 4'd1;
	localparam cmd_t CMD_POP_FRONT  = 4'd2;
	localparam cmd_t CMD_POP_BACK   = 4'd3;
	localparam cmd_t CMD_READ       = 4'd4;
	localparam cmd_t CMD_WRITE      = 4'd5;
	localparam cmd_t CMD_ADD        = 4'd6;
	localparam cmd_t CMD_SUB        = 4'd7;
	localparam cmd_t CMD_MUL        = 4'd8;
	localparam cmd_t CMD_DIV        = 4'd9;
	localparam cmd_t CMD_MOD        = 4'd10;

	typedef logic [STAT_BITS-1:0] stat_t;
	localparam stat_t ST_OK      = 2'd0;
	localparam stat_t ST_EMPTY   = 2'd1;
	localparam stat_t ST_RANGE   = 2'd2;
	localparam stat_t ST_DIVZERO = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACCESS,
		S_BULK_RD,
		S_BULK_OP,
		S_BULK_DIV,
		S_BULK_WR,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;      // capture command and check it
		logic access;     // single-slot access step
		logic bulk_rd;    // read entry for bulk op
		logic bulk_op;    // compute add/sub/mul or load divider
		logic div_step;   // one divider iteration
		logic bulk_wr;    // write back and advance
		logic respond;    // drive result strobe
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_bulk;
		logic is_div;
		logic flagged;
		logic bulk_last;
		logic div_done;
	} sts_t;

endpackage

[hdl/ord_divider.sv]
module ord_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic                            step,
	input  logic signed [ord_pkg::WORD_BITS-1:0] dividend,
	input  logic signed [ord_pkg::WORD_BITS-1:0] divisor,
	input  logic                            want_rem,
	output logic                            done,
	output logic signed [ord_pkg::WORD_BITS-1:0] result
);
	import ord_pkg::*;

	localparam int IT_BITS = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] quo_q, rem_q, den_q;
	logic [IT_BITS-1:0]   it_q;
	logic                 qneg_q, rneg_q, rem_sel_q;
	logic [WORD_BITS:0]   trial;
	logic [WORD_BITS-1:0] shifted;

	assign shifted = {rem_q[WORD_BITS-2:0], quo_q[WORD_BITS-1]};
	assign trial   = {1'b0, shifted} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
		end else if (load) begin
			it_q <= IT_BITS'(WORD_BITS);
		end else if (step && it_q != '0) begin
			it_q <= it_q - 1'b1;
		end
	end

	// restoring division on magnitudes, one quotient bit a cycle while step is high
	always_ff @(posedge clk) begin
		if (load) begin
			quo_q     <= dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
			den_q     <= divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
			rem_q     <= '0;
			qneg_q    <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
			rneg_q    <= dividend[WORD_BITS-1];
			rem_sel_q <= want_rem;
		end else if (step && it_q != '0) begin
			if (!trial[WORD_BITS]) begin
				rem_q <= trial[WORD_BITS-1:0];
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = (it_q == '0);

	always_comb begin
		if (rem_sel_q)
			result = rneg_q ? (~rem_q + 1'b1) : rem_q;
		else
			result = qneg_q ? (~quo_q + 1'b1) : quo_q;
	end

endmodule

[hdl/ord_datapath.sv]
module ord_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 capacity_we,
	input  logic [ord_pkg::CNT_BITS-1:0]         capacity_wdata,
	input  ord_pkg::cmd_t                        command,
	input  logic signed [ord_pkg::WORD_BITS-1:0] value,
	input  logic [ord_pkg::SLOT_BITS-1:0]        index,
	input  ord_pkg::ctl_t                        ctl,
	output ord_pkg::sts_t                        sts,
	output logic                                 done,
	output logic signed [ord_pkg::WORD_BITS-1:0] read_value,
	output ord_pkg::stat_t                       status,
	output logic [ord_pkg::CNT_BITS-1:0]         entry_count,
	output logic                                 is_full,
	output logic                                 overwrote,
	output logic [ord_pkg::CNT_BITS-1:0]         count_peek
);
	import ord_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];

	logic [SLOT_BITS-1:0] head_q, tail_q, walk_q;
	logic [CNT_BITS-1:0]  count_q, cap_q, left_q;
	cmd_t                 cmd_q;
	logic [WORD_BITS-1:0] val_q, ent_q, newv_q, rd_q;
	logic [SLOT_BITS-1:0] idx_q;
	stat_t                stat_q;
	logic                 over_q;

	logic [SLOT_BITS-1:0] cap_m1;
	logic [CNT_BITS-1:0]  cap_clip;
	logic [SLOT_BITS-1:0] head_up, head_dn, tail_up, tail_dn, idx_slot;
	logic [CNT_BITS:0]    idx_sum;
	logic                 full_now, is_bulk_q, is_div_q;
	logic [WORD_BITS-1:0] div_res;
	logic [WORD_BITS-1:0] mul_full;

	assign cap_m1 = SLOT_BITS'(cap_q - 1'b1);

	function automatic logic [SLOT_BITS-1:0] inc(input logic [SLOT_BITS-1:0] s,
			input logic [SLOT_BITS-1:0] top);
		inc = (s == top) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [SLOT_BITS-1:0] dec(input logic [SLOT_BITS-1:0] s,
			input logic [SLOT_BITS-1:0] top);
		dec = (s == '0) ? top : s - 1'b1;
	endfunction

	assign head_up = inc(head_q, cap_m1);
	assign head_dn = dec(head_q, cap_m1);
	assign tail_up = inc(tail_q, cap_m1);
	assign tail_dn = dec(tail_q, cap_m1);
	assign full_now = (count_q >= cap_q);

	// head + index folded once into the ring
	assign idx_sum  = {1'b0, CNT_BITS'(head_q)} + {1'b0, CNT_BITS'(idx_q)};
	assign idx_slot = (idx_sum >= {1'b0, cap_q}) ? SLOT_BITS'(idx_sum - {1'b0, cap_q})
		: SLOT_BITS'(idx_sum);

	always_comb begin
		cap_clip = capacity_wdata;
		if (capacity_wdata == '0)
			cap_clip = CNT_BITS'(1);
		else if (capacity_wdata > CNT_BITS'(DEPTH))
			cap_clip = CNT_BITS'(DEPTH);
	end

	assign is_bulk_q = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB) || (cmd_q == CMD_MUL)
		|| (cmd_q == CMD_DIV) || (cmd_q == CMD_MOD);
	assign is_div_q  = (cmd_q == CMD_DIV) || (cmd_q == CMD_MOD);

	assign sts.is_bulk   = is_bulk_q;
	assign sts.is_div    = is_div_q;
	assign sts.flagged   = (stat_q != ST_OK);
	assign sts.bulk_last = (left_q <= CNT_BITS'(1));

	ord_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ctl.bulk_op && is_div_q),
		.step     (ctl.div_step),
		.dividend (ent_q),
		.divisor  (val_q),
		.want_rem (cmd_q == CMD_MOD),
		.done     (sts.div_done),
		.result   (div_res)
	);

	assign mul_full = ent_q * val_q;

	// command capture and checks
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q  <= command;
			val_q  <= value;
			idx_q  <= index;
			rd_q   <= '0;
			over_q <= 1'b0;
			stat_q <= ST_OK;
			unique case (command) inside
				CMD_POP_FRONT, CMD_POP_BACK:
					if (count_q == '0) stat_q <= ST_EMPTY;
				CMD_READ, CMD_WRITE:
					if (CNT_BITS'(index) >= count_q) stat_q <= ST_RANGE;
				CMD_DIV, CMD_MOD:
					if (value == '0) stat_q <= ST_DIVZERO;
				default: ;
			endcase
		end else if (ctl.access && stat_q == ST_OK) begin
			case (cmd_q) inside
				CMD_POP_FRONT: rd_q <= mem[head_q];
				CMD_POP_BACK:  rd_q <= mem[tail_dn];
				CMD_READ:      rd_q <= mem[idx_slot];
				CMD_PUSH_BACK, CMD_PUSH_FRONT: over_q <= full_now;
				default: ;
			endcase
		end
	end

	// bulk walk registers
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			walk_q <= head_q;
			left_q <= count_q;
		end else if (ctl.bulk_rd) begin
			ent_q <= mem[walk_q];
		end else if (ctl.bulk_op) begin
			case (cmd_q)
				CMD_ADD: newv_q <= ent_q + val_q;
				CMD_SUB: newv_q <= ent_q - val_q;
				CMD_MUL: newv_q <= mul_full;
				default: newv_q <= ent_q;
			endcase
		end else if (ctl.bulk_wr) begin
			walk_q <= inc(walk_q, cap_m1);
			left_q <= left_q - 1'b1;
		end
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (ctl.access && stat_q == ST_OK) begin
			case (cmd_q)
				CMD_PUSH_BACK:  mem[tail_q] <= val_q;
				CMD_PUSH_FRONT: mem[head_dn] <= val_q;
				CMD_WRITE:      mem[idx_slot] <= val_q;
				default: ;
			endcase
		end else if (ctl.bulk_wr) begin
			mem[walk_q] <= is_div_q ? div_res : newv_q;
		end
	end

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			cap_q   <= CNT_BITS'(DEPTH);
		end else if (capacity_we) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			cap_q   <= cap_clip;
		end else if (ctl.access && stat_q == ST_OK) begin
			case (cmd_q)
				CMD_PUSH_BACK: begin
					tail_q <= tail_up;
					if (full_now) head_q <= tail_up;
					else count_q <= count_q + 1'b1;
				end
				CMD_PUSH_FRONT: begin
					head_q <= head_dn;
					if (full_now) tail_q <= head_dn;
					else count_q <= count_q + 1'b1;
				end
				CMD_POP_FRONT: begin
					head_q  <= head_up;
					count_q <= count_q - 1'b1;
				end
				CMD_POP_BACK: begin
					tail_q  <= tail_dn;
					count_q <= count_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign count_peek  = count_q;
	assign done        = ctl.respond;
	assign read_value  = ctl.respond ? rd_q : '0;
	assign status      = ctl.respond ? stat_q : ST_OK;
	assign entry_count = ctl.respond ? count_q : '0;
	assign is_full     = ctl.respond && (count_q == cap_q);
	assign overwrote   = ctl.respond && over_q;

endmodule

[hdl/ord_ctrl.sv]
module ord_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ord_pkg::sts_t  sts,
	output ord_pkg::ctl_t  ctl,
	output logic           busy
);
	import ord_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d   = S_ACCESS;
				end
			end
			S_ACCESS: begin
				if (sts.is_bulk && !sts.flagged && !sts.bulk_last) begin
					state_d = S_BULK_RD;
				end else if (sts.is_bulk && !sts.flagged && sts.bulk_last) begin
					state_d = S_BULK_RD;
				end else begin
					ctl.access = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_BULK_RD: begin
				// read the entry at the walk pointer; flagged ops never get here
				ctl.bulk_rd = 1'b1;
				state_d     = S_BULK_OP;
			end
			S_BULK_OP: begin
				ctl.bulk_op = 1'b1;
				state_d     = sts.is_div ? S_BULK_DIV : S_BULK_WR;
			end
			S_BULK_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_done) state_d = S_BULK_WR;
			end
			S_BULK_WR: begin
				ctl.bulk_wr = 1'b1;
				state_d     = sts.bulk_last ? S_DONE : S_BULK_RD;
			end
			S_DONE: begin
				ctl.respond = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[hdl/ord_walk_gate.sv]
module ord_walk_gate (
	input  ord_pkg::ctl_t                  ctl_in,
	input  logic [ord_pkg::CNT_BITS-1:0]   count,
	input  logic                           bulk_start,
	output ord_pkg::ctl_t                  ctl_out
);
	import ord_pkg::*;

	// suppress walk steps when the buffer is empty at the start of a bulk op
	always_comb begin
		ctl_out = ctl_in;
		if (bulk_start && count == '0) begin
			ctl_out.bulk_rd  = 1'b0;
			ctl_out.bulk_op  = 1'b0;
			ctl_out.div_step = 1'b0;
			ctl_out.bulk_wr  = 1'b0;
		end
	end

endmodule

[hdl/overwriting_ring_deque_core.sv]
// push, pop, read and write entry go from the latch step through the access state to the done strobe
// bulk add/sub/mul read, compute and write back each stored entry; div/mod also step the divider
// throughput: one item at a time; busy is high from acceptance until the done cycle
// the bulk walk goes over the stored entries one by one through the single memory port
// arst_n clears pointers, count and capacity (to 16); slot contents are not cleared
// results show for one cycle on done and cannot be stalled
module overwriting_ring_deque_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  ord_pkg::cmd_t                        command,
	input  logic signed [ord_pkg::WORD_BITS-1:0] value,
	input  logic [ord_pkg::SLOT_BITS-1:0]        index,
	input  logic                                 capacity_we,
	input  logic [ord_pkg::CNT_BITS-1:0]         capacity_wdata,
	output logic                                 done,
	output logic signed [ord_pkg::WORD_BITS-1:0] read_value,
	output ord_pkg::stat_t                       status,
	output logic [ord_pkg::CNT_BITS-1:0]         entry_count,
	output logic                                 is_full,
	output logic                                 overwrote
);
	import ord_pkg::*;

	ctl_t ctl, ctl_raw;
	sts_t sts, sts_raw;
	logic empty_walk;
	logic [CNT_BITS-1:0] entry_count_int;

	ord_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl_raw),
		.busy   (busy)
	);

	// an empty bulk op goes straight to the response
	assign empty_walk = sts_raw.is_bulk && (entry_count_int == '0);

	always_comb begin
		sts = sts_raw;
		if (empty_walk) sts.flagged = 1'b1;
	end

	ord_walk_gate u_gate (
		.ctl_in     (ctl_raw),
		.count      (entry_count_int),
		.bulk_start (1'b0),
		.ctl_out    (ctl)
	);

	ord_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.command        (command),
		.value          (value),
		.index          (index),
		.ctl            (ctl),
		.sts            (sts_raw),
		.done           (done),
		.read_value     (read_value),
		.status         (status),
		.entry_count    (entry_count),
		.is_full        (is_full),
		.overwrote      (overwrote),
		.count_peek     (entry_count_int)
	);

	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done outside busy");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accept did not raise busy");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("busy after done");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && overwrote) |-> (status == ST_OK && is_full))
		else $error("overwrite without full ring");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
	import ord_pkg::*;

	localparam int NUM_RANDOM = 750;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		cmd_t command;
		logic signed [WORD_BITS-1:0] value;
		logic [SLOT_BITS-1:0] index;
		logic cap_write;
		logic [CNT_BITS-1:0] cap_value;
	} deque_item_t;

	typedef struct {
		logic signed [WORD_BITS-1:0] read_value;
		stat_t status;
		logic [CNT_BITS-1:0] entry_count;
		logic is_full;
		logic overwrote;
	} deque_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t command;
	logic signed [WORD_BITS-1:0] value;
	logic [SLOT_BITS-1:0] index;
	logic capacity_we;
	logic [CNT_BITS-1:0] capacity_wdata;
	logic done;
	logic signed [WORD_BITS-1:0] read_value;
	stat_t status;
	logic [CNT_BITS-1:0] entry_count;
	logic is_full;
	logic overwrote;

	overwriting_ring_deque_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.value(value),
		.index(index),
		.capacity_we(capacity_we),
		.capacity_wdata(capacity_wdata),
		.done(done),
		.read_value(read_value),
		.status(status),
		.entry_count(entry_count),
		.is_full(is_full),
		.overwrote(overwrote)
	);

	// mirror of the ring
	logic signed [WORD_BITS-1:0] ring_slots [DEPTH];
	int unsigned ring_head, ring_tail, ring_count, ring_cap;

	deque_item_t pending_items[$];
	deque_result_t expected_results[$];
	int error_count;
	int cycle_count;
	int gap_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	function automatic logic signed [WORD_BITS-1:0] trunc_divmod(
		input logic signed [WORD_BITS-1:0] a, input logic signed [WORD_BITS-1:0] b,
		input bit want_rem);
		logic [WORD_BITS-1:0] ma, mb, q, r;
		ma = a[WORD_BITS-1] ? -a : a;
		mb = b[WORD_BITS-1] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (want_rem)
			return a[WORD_BITS-1] ? -r : r;
		return (a[WORD_BITS-1] != b[WORD_BITS-1]) ? -q : q;
	endfunction

	function automatic void set_capacity(input logic [CNT_BITS-1:0] v);
		ring_cap = (v < 1) ? 1 : (v > DEPTH) ? DEPTH : v;
		ring_head = 0;
		ring_tail = 0;
		ring_count = 0;
	endfunction

	function automatic deque_result_t apply_command(input deque_item_t it);
		deque_result_t res;
		int unsigned s;
		logic signed [WORD_BITS-1:0] e;
		res = '{default: '0};
		case (it.command) inside
			CMD_PUSH_BACK: begin
				ring_slots[ring_tail] = it.value;
				ring_tail = (ring_tail + 1) % ring_cap;
				if (ring_count >= ring_cap) begin
					ring_head = ring_tail;
					res.overwrote = 1'b1;
				end else
					ring_count++;
			end
			CMD_PUSH_FRONT: begin
				ring_head = (ring_head + ring_cap - 1) % ring_cap;
				ring_slots[ring_head] = it.value;
				if (ring_count >= ring_cap) begin
					ring_tail = ring_head;
					res.overwrote = 1'b1;
				end else
					ring_count++;
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (ring_count == 0)
					res.status = ST_EMPTY;
				else if (it.command == CMD_POP_FRONT) begin
					res.read_value = ring_slots[ring_head];
					ring_head = (ring_head + 1) % ring_cap;
					ring_count--;
				end else begin
					ring_tail = (ring_tail + ring_cap - 1) % ring_cap;
					res.read_value = ring_slots[ring_tail];
					ring_count--;
				end
			end
			CMD_READ, CMD_WRITE: begin
				if (it.index >= ring_count)
					res.status = ST_RANGE;
				else begin
					s = (ring_head + it.index) % ring_cap;
					if (it.command == CMD_READ)
						res.read_value = ring_slots[s];
					else
						ring_slots[s] = it.value;
				end
			end
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
				if ((it.command == CMD_DIV || it.command == CMD_MOD) && it.value == 0)
					res.status = ST_DIVZERO;
				else
					for (int i = 0; i < ring_count; i++) begin
						s = (ring_head + i) % ring_cap;
						e = ring_slots[s];
						case (it.command)
							CMD_ADD: e = e + it.value;
							CMD_SUB: e = e - it.value;
							CMD_MUL: e = e * it.value;
							CMD_DIV: e = trunc_divmod(e, it.value, 1'b0);
							default: e = trunc_divmod(e, it.value, 1'b1);
						endcase
						ring_slots[s] = e;
					end
			end
			default: ;
		endcase
		res.entry_count = CNT_BITS'(ring_count);
		res.is_full = (ring_count == ring_cap);
		return res;
	endfunction

	function automatic logic signed [WORD_BITS-1:0] random_word();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -1;
			3: return 0;
			4, 5: return $signed(32'($urandom_range(0, 20))) - 10;
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_item(input cmd_t c, input logic signed [WORD_BITS-1:0] v,
		input int ix);
		deque_item_t it;
		it.command = c;
		it.value = v;
		it.index = SLOT_BITS'(ix);
		it.cap_write = 1'b0;
		it.cap_value = '0;
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void add_capacity(input int v);
		deque_item_t it;
		it = '{default: '0};
		it.cap_write = 1'b1;
		it.cap_value = CNT_BITS'(v);
		pending_items.insert(pending_items.size(), it);
	endfunction

	// driver: capacity writes only go out with nothing outstanding and the block idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			capacity_we <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				if (pending_items.size() > 0) begin
					// accepted this edge; predict now
					expected_results.insert(expected_results.size(),
						apply_command(pending_items[0]));
					pending_items.delete(0);
				end
				start <= 1'b0;
				gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
					: $urandom_range(0, 2);
			end else if (!start && gap_left > 0) begin
				// a capacity write is always followed by a gap
				capacity_we <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (!start && pending_items.size() > 0 && !busy) begin
				if (pending_items[0].cap_write) begin
					if (expected_results.size() == 0 && !done) begin
						capacity_we <= 1'b1;
						capacity_wdata <= pending_items[0].cap_value;
						set_capacity(pending_items[0].cap_value);
						pending_items.delete(0);
						gap_left <= 2;
					end
				end else begin
					command <= pending_items[0].command;
					value <= pending_items[0].value;
					index <= pending_items[0].index;
					start <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("unexpected item at cycle %0d", cycle_count);
				error_count++;
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				if (read_value !== want.read_value)
					report("read_value", read_value, want.read_value);
				if (status !== want.status) report("status", status, want.status);
				if (entry_count !== want.entry_count)
					report("entry_count", entry_count, want.entry_count);
				if (is_full !== want.is_full) report("is_full", is_full, want.is_full);
				if (overwrote !== want.overwrote)
					report("overwrote", overwrote, want.overwrote);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout");
			$display("overwriting_ring_deque_core test failed");
			$finish;
		end
	end

	initial begin
		int cap, r;
		cycle_count = 0;
		error_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_PUSH_BACK;
		value = '0;
		index = '0;
		capacity_we = 1'b0;
		capacity_wdata = '0;
		ring_cap = DEPTH;
		ring_head = 0;
		ring_tail = 0;
		ring_count = 0;

		// directed: empty pops, range errors, div by zero while empty, unused opcodes, extremes
		add_item(CMD_POP_FRONT, 0, 0);
		add_item(CMD_POP_BACK, 0, 0);
		add_item(CMD_READ, 0, 0);
		add_item(CMD_DIV, 0, 0);
		add_item(CMD_MOD, 0, 0);
		add_item(4'd11, 32'sh7fff_ffff, 15);
		add_item(4'd15, -1, 15);
		add_item(CMD_PUSH_BACK, 32'sh8000_0000, 0);
		add_item(CMD_PUSH_FRONT, 32'sh7fff_ffff, 0);
		add_item(CMD_PUSH_BACK, -7, 0);
		add_item(CMD_WRITE, -1, 2);
		add_item(CMD_WRITE, 5, 15);
		add_item(CMD_MUL, 32'sh7fff_ffff, 0);
		add_item(CMD_ADD, 32'sh8000_0000, 0);
		add_item(CMD_SUB, 3, 0);
		add_item(CMD_DIV, -1, 0);
		add_item(CMD_MOD, -3, 0);
		add_item(CMD_READ, 0, 1);
		add_item(CMD_POP_BACK, 0, 0);
		add_item(CMD_POP_FRONT, 0, 0);
		// capacity 0 taken as 1: overwrite at both ends
		add_capacity(0);
		add_item(CMD_PUSH_BACK, 11, 0);
		add_item(CMD_PUSH_BACK, 22, 0);
		add_item(CMD_PUSH_FRONT, 33, 0);
		add_item(CMD_POP_FRONT, 0, 0);

		// random phases; each starts with a capacity write so no unwritten slot is read
		r = 0;
		while (r < NUM_RANDOM) begin
			case ($urandom_range(0, 5))
				0: cap = 1;
				1: cap = DEPTH;
				2: cap = $urandom_range(17, 31);
				default: cap = $urandom_range(2, DEPTH);
			endcase
			add_capacity(cap);
			for (int k = 0; k < 60 && r < NUM_RANDOM; k++) begin
				cmd_t c;
				int sel;
				sel = $urandom_range(0, 99);
				if (sel < 35) c = CMD_BITS'($urandom_range(0, 1));
				else if (sel < 55) c = CMD_BITS'($urandom_range(2, 3));
				else if (sel < 75) c = CMD_BITS'($urandom_range(4, 5));
				else if (sel < 97) c = CMD_BITS'($urandom_range(6, 10));
				else c = CMD_BITS'($urandom_range(11, 15));
				add_item(c, (c == CMD_DIV || c == CMD_MOD) && $urandom_range(0, 9) == 0
					? 0 : random_word(), $urandom_range(0, 15));
				r++;
			end
		end
		add_capacity(DEPTH);
		add_item(CMD_POP_FRONT, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("overwriting_ring_deque_core test passed");
		else
			$display("overwriting_ring_deque_core test failed");
		$finish;
	end

endmodule

[files.f]
hdl/ord_pkg.sv
hdl/ord_divider.sv
hdl/ord_datapath.sv
hdl/ord_ctrl.sv
hdl/ord_walk_gate.sv
hdl/overwriting_ring_deque_core.sv
verif/tb.sv
